[design/http_request_line_path_parser_unit_macros.svh]
// ----------------------------------------------------------------------------
// http request line path parser - assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PATH_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_PATH_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define HRLP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HRLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/hrlp_pkg.sv]
// ----------------------------------------------------------------------------
// hrlp_pkg
// shared types, constants and the hex digit formula of the path parser
// ----------------------------------------------------------------------------
package hrlp_pkg;

   localparam int PATH_DEPTH   = 256;
   localparam int LEN_W        = $clog2(PATH_DEPTH + 1);
   localparam int SP_W         = LEN_W + 1;
   localparam int MAX_LEN_W    = 9;
   localparam int PATH_LEN_W   = 9;
   localparam int PATH_INDEX_W = 8;
   localparam int CMP_W        = ((LEN_W > MAX_LEN_W) ? LEN_W : MAX_LEN_W) + 1;
   localparam int INDEX_FILE_LEN = 12;

   localparam logic [8:0] MAX_LEN_RESET = 9'd255;

   localparam logic [1:0] VERDICT_OK        = 2'd0;
   localparam logic [1:0] VERDICT_NOT_IMPL  = 2'd1;
   localparam logic [1:0] VERDICT_BAD_REQ   = 2'd2;
   localparam logic [1:0] VERDICT_TOO_LONG  = 2'd3;

   localparam logic [1:0] HEX_IDLE = 2'd0;
   localparam logic [1:0] HEX_HIGH = 2'd1;
   localparam logic [1:0] HEX_LOW  = 2'd2;

   localparam logic [7:0] CHAR_MASK = 8'b0111_1111;
   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       new_request;
   } hrlp_item_type;

   typedef struct packed {
      logic                    path_write;
      logic [PATH_INDEX_W-1:0] path_index;
      logic [7:0]              path_byte;
      logic                    done_res;
      logic [1:0]              verdict;
      logic                    is_get;
      logic [PATH_LEN_W-1:0]   path_length;
      logic                    add_index_file;
   } hrlp_result_type;

   function automatic logic [7:0] digit_value(input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] d;
      c = b & CHAR_MASK;
      d = c - CHAR_A_UP;
      if (c < CHAR_A_UP) begin
         return c - CHAR_ZERO;
      end
      return {3'b000, d[4:0]} + 8'd10;
   endfunction

endpackage

[design/hrlp_input_stage.sv]
// ----------------------------------------------------------------------------
// hrlp_input_stage
// input register: holds one request transaction until the core takes it
// ----------------------------------------------------------------------------
module hrlp_input_stage import hrlp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_rx_byte,
   input  logic          req_new_request,
   input  logic          take,
   output logic          item_valid,
   output hrlp_item_type item
);

   logic          valid_ff, valid_in;
   hrlp_item_type item_ff, item_in;
   logic          accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in            = 1'b1;
         item_in.rx_byte     = req_rx_byte;
         item_in.new_request = req_new_request;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/hrlp_parser_core.sv]
// ----------------------------------------------------------------------------
// hrlp_parser_core
// parser state, per-byte next-state logic and the result register
// ----------------------------------------------------------------------------
module hrlp_parser_core import hrlp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [8:0]      csr_write_data,
   input  logic            item_valid,
   input  hrlp_item_type   item,
   output logic            take,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output hrlp_result_type result
);

   typedef enum logic [3:0] {
      PH_M0, PH_M1_G, PH_M1_H, PH_M1_X, PH_M2_G, PH_M2_H, PH_M2_X,
      PH_M3, PH_SP, PH_SL, PH_PATH, PH_DONE
   } phase_type;

   localparam int SW = SP_W + 1;

   phase_type              phase_ff, phase_in, cur_phase;
   logic                   method_get_ff, method_get_in, cur_get;
   logic [1:0]             hex_ff, hex_in, cur_hex;
   logic [7:0]             high_ff, high_in, cur_high;
   logic [LEN_W-1:0]       len_ff, len_in, cur_len;
   logic signed [SP_W-1:0] sp_ff, sp_in, cur_sp;
   logic [1:0]             dots_ff, dots_in, cur_dots;
   logic                   last_slash_ff, last_slash_in, cur_last;
   logic [8:0]             max_len_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   hrlp_result_type        result_ff, result_in;

   logic                   fire;
   logic                   byte_go;
   logic [7:0]             pb;
   logic [7:0]             b;
   logic signed [SW-1:0]   len_s, sp_s, idx_s;
   logic [CMP_W-1:0]       len_c, max_c;
   logic                   add_idx;
   logic                   stop;

   assign take = !rsp_valid_ff || !rsp_stall;
   assign fire = item_valid && take;
   assign b    = item.rx_byte;

   always_comb begin
      if (item.new_request) begin
         cur_phase = PH_M0;
         cur_get   = 1'b0;
         cur_hex   = HEX_IDLE;
         cur_high  = '0;
         cur_len   = '0;
         cur_sp    = '1;
         cur_dots  = '0;
         cur_last  = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_get   = method_get_ff;
         cur_hex   = hex_ff;
         cur_high  = high_ff;
         cur_len   = len_ff;
         cur_sp    = sp_ff;
         cur_dots  = dots_ff;
         cur_last  = last_slash_ff;
      end

      phase_in      = cur_phase;
      method_get_in = cur_get;
      hex_in        = cur_hex;
      high_in       = cur_high;
      len_in        = cur_len;
      sp_in         = cur_sp;
      dots_in       = cur_dots;
      last_slash_in = cur_last;
      result_in     = '0;
      byte_go       = 1'b0;
      pb            = b;
      stop          = 1'b0;
      len_c         = CMP_W'(cur_len);
      max_c         = CMP_W'(max_len_ff);
      add_idx       = 1'b0;
      len_s         = '0;
      sp_s          = '0;
      idx_s         = '0;

      unique case (cur_phase)
         PH_M0: begin
            phase_in = (b == "G") ? PH_M1_G : ((b == "H") ? PH_M1_H : PH_M1_X);
         end
         PH_M1_G: phase_in = (b == "E") ? PH_M2_G : PH_M2_X;
         PH_M1_H: phase_in = (b == "E") ? PH_M2_H : PH_M2_X;
         PH_M1_X: phase_in = PH_M2_X;
         PH_M2_G: begin
            if (b == "T") begin
               method_get_in = 1'b1;
               phase_in      = PH_SP;
            end else begin
               stop              = 1'b1;
               result_in.verdict = VERDICT_NOT_IMPL;
            end
         end
         PH_M2_H: begin
            if (b == "A") begin
               phase_in = PH_M3;
            end else begin
               stop              = 1'b1;
               result_in.verdict = VERDICT_NOT_IMPL;
            end
         end
         PH_M2_X: begin
            stop              = 1'b1;
            result_in.verdict = VERDICT_NOT_IMPL;
         end
         PH_M3: begin
            if (b == "D") begin
               method_get_in = 1'b0;
               phase_in      = PH_SP;
            end else begin
               stop              = 1'b1;
               result_in.verdict = VERDICT_NOT_IMPL;
            end
         end
         PH_SP: begin
            if (b == " ") begin
               phase_in = PH_SL;
            end else begin
               stop              = 1'b1;
               result_in.verdict = VERDICT_BAD_REQ;
            end
         end
         PH_SL: begin
            if (b == "/") begin
               phase_in = PH_PATH;
            end else begin
               stop              = 1'b1;
               result_in.verdict = VERDICT_BAD_REQ;
            end
         end
         PH_PATH: begin
            if (cur_hex == HEX_HIGH) begin
               high_in = digit_value(b);
               hex_in  = HEX_LOW;
            end else if (cur_hex == HEX_LOW) begin
               pb      = {cur_high[3:0], 4'b0000} + digit_value(b);
               hex_in  = HEX_IDLE;
               byte_go = 1'b1;
            end else if (b == " ") begin
               stop = 1'b1;
               if (len_c > max_c) begin
                  result_in.verdict = VERDICT_TOO_LONG;
               end else begin
                  add_idx = (cur_len == '0) || cur_last;
                  result_in.add_index_file = add_idx;
                  if (add_idx && (len_c + CMP_W'(INDEX_FILE_LEN) > max_c)) begin
                     result_in.verdict = VERDICT_TOO_LONG;
                  end
               end
            end else if (b == "%") begin
               hex_in = HEX_HIGH;
            end else begin
               byte_go = 1'b1;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (byte_go) begin
         len_s = SW'(signed'({1'b0, cur_len}));
         sp_s  = SW'(cur_sp);
         if (pb == "/" && len_s < sp_s + SW'(2)) begin
            stop              = 1'b1;
            result_in.verdict = VERDICT_BAD_REQ;
         end else if (pb == "/" && len_s == sp_s + SW'(3) && cur_dots == 2'b11) begin
            len_in        = cur_sp[SP_W-1] ? '0 : cur_sp[LEN_W-1:0];
            last_slash_in = 1'b0;
         end else begin
            if (pb == "/") begin
               sp_s    = len_s;
               sp_in   = SP_W'(len_s);
               dots_in = '0;
            end
            idx_s = len_s;
            if (idx_s == sp_s + SW'(1)) begin
               dots_in[0] = (pb == ".");
            end else if (idx_s == sp_s + SW'(2)) begin
               dots_in[1] = (pb == ".");
            end
            if (cur_len < LEN_W'(PATH_DEPTH)) begin
               result_in.path_write = 1'b1;
               result_in.path_index = PATH_INDEX_W'(cur_len);
               result_in.path_byte  = pb;
               len_in               = cur_len + LEN_W'(1);
            end
            last_slash_in = (pb == "/");
         end
      end

      if (stop) begin
         phase_in                 = PH_DONE;
         result_in.done_res       = 1'b1;
         result_in.is_get         = cur_get;
         result_in.path_length    = PATH_LEN_W'(cur_len);
      end

      rsp_valid_in = fire ? 1'b1 : (take ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_M0;
         method_get_ff <= 1'b0;
         hex_ff        <= HEX_IDLE;
         high_ff       <= '0;
         len_ff        <= '0;
         sp_ff         <= '1;
         dots_ff       <= '0;
         last_slash_ff <= 1'b0;
         max_len_ff    <= MAX_LEN_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff      <= phase_in;
            method_get_ff <= method_get_in;
            hex_ff        <= hex_in;
            high_ff       <= high_in;
            len_ff        <= len_in;
            sp_ff         <= sp_in;
            dots_ff       <= dots_in;
            last_slash_ff <= last_slash_in;
         end
         if (csr_write_enable) begin
            max_len_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

[design/http_request_line_path_parser_unit.sv]
// a request transaction is held in the input register, then its result in the result register
// throughput: one byte per cycle while the result channel does not stall, set by the state update of the core
// the input and result registers let a new byte enter while a result waits
// reset: synchronous, active high; parser restarts, limit returns to 255
// ----------------------------------------------------------------------------
// http_request_line_path_parser_unit
// byte-wise http request line parser with path decoding and verdicts
// ----------------------------------------------------------------------------
module http_request_line_path_parser_unit import hrlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_new_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_path_write,
   output logic [7:0]  rsp_path_index,
   output logic [7:0]  rsp_path_byte,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_is_get,
   output logic [8:0]  rsp_path_length,
   output logic        rsp_add_index_file
);

   logic            take;
   logic            item_valid;
   hrlp_item_type   item;
   hrlp_result_type result;

   hrlp_input_stage u_input (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_new_request (req_new_request),
      .take            (take),
      .item_valid      (item_valid),
      .item            (item)
   );

   hrlp_parser_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .result           (result)
   );

   assign rsp_path_write     = result.path_write;
   assign rsp_path_index     = result.path_index;
   assign rsp_path_byte      = result.path_byte;
   assign rsp_done_res       = result.done_res;
   assign rsp_verdict        = result.verdict;
   assign rsp_is_get         = result.is_get;
   assign rsp_path_length    = result.path_length;
   assign rsp_add_index_file = result.add_index_file;

endmodule

[design/hrlp_checker.sv]
// ----------------------------------------------------------------------------
// hrlp_checker
// port-level checks of the path parser result channel
// ----------------------------------------------------------------------------
`include "http_request_line_path_parser_unit_macros.svh"

module hrlp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_path_write,
   input logic [7:0] rsp_path_index,
   input logic [7:0] rsp_path_byte,
   input logic       rsp_done_res,
   input logic [1:0] rsp_verdict,
   input logic       rsp_is_get,
   input logic [8:0] rsp_path_length,
   input logic       rsp_add_index_file
);

   `HRLP_ASSERT_NOW(a_no_write_zero, clock, reset, rsp_valid && !rsp_path_write, rsp_path_index == 8'd0 && rsp_path_byte == 8'd0, "write fields set without a write")
   `HRLP_ASSERT_NOW(a_no_done_zero, clock, reset, rsp_valid && !rsp_done_res, rsp_verdict == 2'd0 && !rsp_is_get && rsp_path_length == 9'd0 && !rsp_add_index_file, "verdict fields set without done")
   `HRLP_ASSERT_NOW(a_done_no_write, clock, reset, rsp_valid && rsp_done_res, !rsp_path_write, "verdict transaction also writes a path byte")
   `HRLP_ASSERT_NOW(a_method_err, clock, reset, rsp_valid && rsp_done_res && rsp_verdict == 2'd1, rsp_path_length == 9'd0 && !rsp_add_index_file, "method error with path data")
   `HRLP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_path_index) && $stable(rsp_verdict), "stalled result changed")

endmodule

bind http_request_line_path_parser_unit hrlp_checker u_hrlp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_path_write     (rsp_path_write),
   .rsp_path_index     (rsp_path_index),
   .rsp_path_byte      (rsp_path_byte),
   .rsp_done_res       (rsp_done_res),
   .rsp_verdict        (rsp_verdict),
   .rsp_is_get         (rsp_is_get),
   .rsp_path_length    (rsp_path_length),
   .rsp_add_index_file (rsp_add_index_file)
);
